// ===== rtl/core/rdg_pkg.sv =====
// shared types, constants and the level table for the ratio drowsiness grader
// no dependencies; every other file in rtl/core refers to it by scoped names
`default_nettype none

package rdg_pkg;

  // default geometry
  localparam int LONG_WINDOW_DEF  = 75;
  localparam int SHORT_WINDOW_DEF = 30;
  localparam int RATIO_BITS_DEF   = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_REFERENCE_MIN  = 2'd0;
  localparam logic [1:0] CFG_REFERENCE_MAX  = 2'd1;
  localparam logic [1:0] CFG_GROUP_LENGTH   = 2'd2;
  localparam logic [1:0] CFG_MAJORITY_COUNT = 2'd3;

  // configuration reset values
  localparam logic [15:0] REFERENCE_MIN_RST  = 16'd512;
  localparam logic [15:0] REFERENCE_MAX_RST  = 16'd1280;
  localparam logic [4:0]  GROUP_LENGTH_RST   = 5'd25;
  localparam logic [4:0]  MAJORITY_COUNT_RST = 5'd17;

  // alert verdicts
  localparam logic [1:0] ALERT_GREEN  = 2'd0;
  localparam logic [1:0] ALERT_YELLOW = 2'd1;
  localparam logic [1:0] ALERT_RED    = 2'd2;

  // grades used before the windows are full
  localparam logic [2:0] RATIO_GRADE_ABOVE = 3'd6;
  localparam logic [2:0] TREND_GRADE_FLAT  = 3'd3;

  // level bands for the alert counters
  localparam logic [2:0] LEVEL_GREEN      = 3'd5;
  localparam logic [2:0] LEVEL_YELLOW_MIN = 3'd3;

  // window status handed from the history to the grader
  typedef struct packed {
    logic active;   // enough history for grading
    logic refresh;  // this beat rebuilds the reference
  } rdg_win_stat_t;

  // level from ratio grade (1..6) and trend grade (1..5)
  function automatic logic [2:0] level_lookup(input logic [2:0] rg, input logic [2:0] tg);
    logic [14:0] row;
    logic [2:0]  col;
    begin
      unique case (rg)
        3'd1:    row = {3'd2, 3'd2, 3'd1, 3'd1, 3'd1};
        3'd2:    row = {3'd3, 3'd2, 3'd2, 3'd1, 3'd1};
        3'd3:    row = {3'd4, 3'd3, 3'd3, 3'd2, 3'd2};
        3'd4:    row = {3'd5, 3'd4, 3'd4, 3'd3, 3'd3};
        3'd5:    row = {3'd5, 3'd5, 3'd5, 3'd5, 3'd4};
        default: row = {3'd5, 3'd5, 3'd5, 3'd5, 3'd5};
      endcase
      col = (tg == 3'd0 || tg > 3'd5) ? 3'd0 : tg - 3'd1;
      level_lookup = row[3*col +: 3];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdg_history.sv =====
// sample shift line, running window sums and their constant-divisor means
// depends on rdg_pkg for the default geometry and the window status struct
`default_nettype none

module rdg_history #(
  parameter int LONG_WINDOW  = rdg_pkg::LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = rdg_pkg::SHORT_WINDOW_DEF,
  parameter int RATIO_BITS   = rdg_pkg::RATIO_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [RATIO_BITS-1:0] ratio,
  output logic [RATIO_BITS-1:0]      long_mean,
  output logic [RATIO_BITS-1:0]      short_mean,
  output rdg_pkg::rdg_win_stat_t     stat
);

  localparam int CNT_W   = $clog2(LONG_WINDOW + 2);
  localparam int PH_W    = $clog2(LONG_WINDOW);
  localparam int LSUM_W  = RATIO_BITS + $clog2(LONG_WINDOW);
  localparam int SSUM_W  = RATIO_BITS + $clog2(SHORT_WINDOW);
  localparam int L_K     = LSUM_W + $clog2(LONG_WINDOW);
  localparam int S_K     = SSUM_W + $clog2(SHORT_WINDOW);
  localparam int ADD_AGE = LONG_WINDOW - SHORT_WINDOW - 1;

  // reciprocals, rounded up, exact for every sum of the given width
  localparam logic [63:0] L_MUL64 =
    ((64'd1 << L_K) + 64'(LONG_WINDOW) - 64'd1) / 64'(LONG_WINDOW);
  localparam logic [63:0] S_MUL64 =
    ((64'd1 << S_K) + 64'(SHORT_WINDOW) - 64'd1) / 64'(SHORT_WINDOW);
  localparam logic [LSUM_W:0] L_MUL = L_MUL64[LSUM_W:0];
  localparam logic [SSUM_W:0] S_MUL = S_MUL64[SSUM_W:0];

  logic [RATIO_BITS-1:0] hist [0:LONG_WINDOW-1];
  logic [RATIO_BITS-1:0] tap  [0:LONG_WINDOW];

  logic [CNT_W-1:0]  sample_count;
  logic [PH_W-1:0]   update_phase;
  logic [LSUM_W-1:0] long_sum, long_sum_next;
  logic [SSUM_W-1:0] short_sum, short_sum_next;

  logic [RATIO_BITS-1:0] long_drop, short_add, short_drop;
  logic [2*LSUM_W:0]     long_prod;
  logic [2*SSUM_W:0]     short_prod;
  logic                  active;

  // tap k is the sample k beats older than the current one
  assign tap[0] = ratio;
  for (genvar k = 1; k <= LONG_WINDOW; k++) begin : g_tap
    assign tap[k] = hist[k-1];
  end

  assign active = (sample_count == CNT_W'(LONG_WINDOW + 1));

  always_comb begin
    // taps not yet written count as zero in the sums
    long_drop  = (sample_count >= CNT_W'(LONG_WINDOW)) ? tap[LONG_WINDOW] : '0;
    short_add  = (sample_count >= CNT_W'(ADD_AGE)) ? tap[ADD_AGE] : '0;
    short_drop = (sample_count >= CNT_W'(LONG_WINDOW - 1)) ? tap[LONG_WINDOW-1] : '0;
    long_sum_next  = long_sum + LSUM_W'(ratio) - LSUM_W'(long_drop);
    short_sum_next = short_sum + SSUM_W'(short_add) - SSUM_W'(short_drop);
    long_prod  = (2*LSUM_W+1)'(long_sum_next) * (2*LSUM_W+1)'(L_MUL);
    short_prod = (2*SSUM_W+1)'(short_sum_next) * (2*SSUM_W+1)'(S_MUL);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hist[0] <= ratio;
      for (int k = 1; k < LONG_WINDOW; k++) begin
        hist[k] <= hist[k-1];
      end
      long_mean  <= long_prod[L_K +: RATIO_BITS];
      short_mean <= short_prod[S_K +: RATIO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      update_phase <= '0;
      long_sum     <= '0;
      short_sum    <= '0;
    end else if (step) begin
      long_sum  <= long_sum_next;
      short_sum <= short_sum_next;
      if (!active) begin
        sample_count <= sample_count + 1'b1;
      end else if (update_phase == PH_W'(LONG_WINDOW - 1)) begin
        update_phase <= '0;
      end else begin
        update_phase <= update_phase + 1'b1;
      end
    end
  end

  assign stat.active  = active;
  assign stat.refresh = active && (update_phase == '0);

endmodule

`default_nettype wire

// ===== rtl/core/rdg_grader.sv =====
// reference level upkeep, ratio and trend grading and the level lookup
// depends on rdg_pkg for the default ratio width, status struct, grade constants and level table
`default_nettype none

module rdg_grader #(
  parameter int RATIO_BITS = rdg_pkg::RATIO_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [RATIO_BITS-1:0]  ratio,
  input  wire logic [RATIO_BITS-1:0]  long_mean,
  input  wire logic [RATIO_BITS-1:0]  short_mean,
  input  wire rdg_pkg::rdg_win_stat_t stat,
  input  wire logic [15:0]            reference_min,
  input  wire logic [15:0]            reference_max,
  output logic [2:0]                  ratio_grade,
  output logic [2:0]                  trend_grade,
  output logic [2:0]                  level
);

  localparam int REF_W = (RATIO_BITS > 16) ? RATIO_BITS : 16;
  localparam int PRD_W = REF_W + 5;
  localparam int DW    = REF_W + 2;

  localparam logic signed [DW-1:0] TH_DROP_BIG  = DW'(256);
  localparam logic signed [DW-1:0] TH_DROP      = DW'(128);
  localparam logic signed [DW-1:0] TH_FLAT      = '0;
  localparam logic signed [DW-1:0] TH_RISE      = DW'(-128);

  logic [REF_W-1:0]      reference_level;
  logic [RATIO_BITS-1:0] previous_mean;
  logic                  first_update_done;

  logic [RATIO_BITS:0]   mean_pair;
  logic [REF_W-1:0]      ref_raw, ref_new, ref_use;
  logic [PRD_W-1:0]      ref_x, r_x;
  logic signed [DW-1:0]  diff;

  always_comb begin
    mean_pair = ({1'b0, previous_mean} + {1'b0, long_mean}) >> 1;
    ref_raw   = first_update_done ? REF_W'(mean_pair) : REF_W'(long_mean);
    // upper limit is checked first; with crossed limits a value above it gets the upper limit, any other the lower
    if (ref_raw > REF_W'(reference_max)) begin
      ref_new = REF_W'(reference_max);
    end else if (ref_raw < REF_W'(reference_min)) begin
      ref_new = REF_W'(reference_min);
    end else begin
      ref_new = ref_raw;
    end
    ref_use = stat.refresh ? ref_new : reference_level;

    ref_x = PRD_W'(ref_use);
    r_x   = PRD_W'(ratio);
    diff  = $signed(DW'(short_mean)) - $signed(DW'(ratio));

    if (!stat.active) begin
      ratio_grade = rdg_pkg::RATIO_GRADE_ABOVE;
      trend_grade = rdg_pkg::TREND_GRADE_FLAT;
    end else begin
      priority if (ref_x <= r_x)                            ratio_grade = 3'd6;
      else if (ref_x * PRD_W'(4) <= r_x * PRD_W'(5))        ratio_grade = 3'd5;
      else if (ref_x * PRD_W'(13) <= r_x * PRD_W'(20))      ratio_grade = 3'd4;
      else if (ref_x <= r_x * PRD_W'(2))                    ratio_grade = 3'd3;
      else if (ref_x * PRD_W'(7) <= r_x * PRD_W'(20))       ratio_grade = 3'd2;
      else                                                  ratio_grade = 3'd1;

      priority if (diff >= TH_DROP_BIG) trend_grade = 3'd1;
      else if (diff >= TH_DROP)         trend_grade = 3'd2;
      else if (diff >= TH_FLAT)         trend_grade = 3'd3;
      else if (diff >= TH_RISE)         trend_grade = 3'd4;
      else                              trend_grade = 3'd5;
    end
    level = rdg_pkg::level_lookup(ratio_grade, trend_grade);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_level   <= '0;
      previous_mean     <= '0;
      first_update_done <= 1'b0;
    end else if (step && stat.refresh) begin
      reference_level   <= ref_new;
      previous_mean     <= long_mean;
      first_update_done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rdg_alert.sv =====
// group counters of green, yellow and red levels and the alert verdict
// depends on rdg_pkg for alert codes and level bands
`default_nettype none

module rdg_alert (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [2:0] level,
  input  wire logic [4:0] group_length,
  input  wire logic [4:0] majority_count,
  output logic [1:0]      alert,
  output logic            closed
);

  logic [4:0] group_position;
  logic [4:0] green_count, yellow_count, red_count;
  logic [4:0] green_base, yellow_base, red_base;
  logic [4:0] green_next, yellow_next, red_next;
  logic [1:0] alert_state, alert_next;

  function automatic logic [4:0] bump(input logic [4:0] c);
    bump = (c == 5'd31) ? c : c + 5'd1;
  endfunction

  always_comb begin
    closed = (group_position == group_length);
    priority if (green_count >= majority_count) alert_next = rdg_pkg::ALERT_GREEN;
    else if (red_count >= majority_count)       alert_next = rdg_pkg::ALERT_RED;
    else                                        alert_next = rdg_pkg::ALERT_YELLOW;
    green_base  = closed ? '0 : green_count;
    yellow_base = closed ? '0 : yellow_count;
    red_base    = closed ? '0 : red_count;
    alert       = closed ? alert_next : alert_state;
    green_next  = green_base;
    yellow_next = yellow_base;
    red_next    = red_base;
    if (level == rdg_pkg::LEVEL_GREEN) begin
      green_next = bump(green_base);
    end else if (level >= rdg_pkg::LEVEL_YELLOW_MIN) begin
      yellow_next = bump(yellow_base);
    end else begin
      red_next = bump(red_base);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 5'd1;
      green_count    <= '0;
      yellow_count   <= '0;
      red_count      <= '0;
      alert_state    <= rdg_pkg::ALERT_YELLOW;
    end else if (step) begin
      group_position <= closed ? 5'd1 : group_position + 5'd1;
      alert_state    <= alert;
      green_count    <= green_next;
      yellow_count   <= yellow_next;
      red_count      <= red_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ratio_drowsiness_grader.sv =====
// top level of the ratio drowsiness grader: stream ports, config registers, beat registers
// depends on rdg_pkg, rdg_history, rdg_grader and rdg_alert
`default_nettype none

//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-----------------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready  | tdata: ratio
//  m_axis  | out       | m_axis_tvalid/m_axis_tready  | tdata: level, grades, alert; tlast
//  cfg     | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// one beat per cycle sustained while the consumer keeps up; a beat waits in the input
// register until it steps, and the step edge loads its result into the output register
// the running window sums and the shift line update in the same cycle as the grading,
// which is what lets the next beat follow straight after
// reset is synchronous and active high; the history taps need no clearing since
// the sums ignore taps until enough beats have been seen
// a stalled output holds its beat; the input register still drains into it as soon
// as the consumer takes the held beat
module ratio_drowsiness_grader #(
  parameter int LONG_WINDOW  = rdg_pkg::LONG_WINDOW_DEF,
  parameter int SHORT_WINDOW = rdg_pkg::SHORT_WINDOW_DEF,
  parameter int RATIO_BITS   = rdg_pkg::RATIO_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input sample stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [((RATIO_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // ratio
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [15:0]                               m_axis_tdata,  // level, ratio_grade,
                                                                   // trend_grade, alert
  output logic                                      m_axis_tlast,  // alert_updated
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [15:0]                          cfg_data
);

  // configuration registers
  logic [15:0] reference_min, reference_max;
  logic [4:0]  group_length, majority_count;

  // input beat register
  logic                  in_valid;
  logic [RATIO_BITS-1:0] ratio_q;
  logic                  step;

  rdg_pkg::rdg_win_stat_t win_stat;
  logic [RATIO_BITS-1:0]  long_mean, short_mean;
  logic [2:0]             ratio_grade, trend_grade, level;
  logic [1:0]             alert;
  logic                   closed;

  // output beat register
  logic [2:0] level_q, ratio_grade_q, trend_grade_q;
  logic [1:0] alert_q;
  logic       closed_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_min  <= rdg_pkg::REFERENCE_MIN_RST;
      reference_max  <= rdg_pkg::REFERENCE_MAX_RST;
      group_length   <= rdg_pkg::GROUP_LENGTH_RST;
      majority_count <= rdg_pkg::MAJORITY_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rdg_pkg::CFG_REFERENCE_MIN:  reference_min  <= cfg_data;
        rdg_pkg::CFG_REFERENCE_MAX:  reference_max  <= cfg_data;
        rdg_pkg::CFG_GROUP_LENGTH:   group_length   <= cfg_data[4:0];
        rdg_pkg::CFG_MAJORITY_COUNT: majority_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // the held beat moves on whenever the output register is free or being emptied
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ratio_q <= s_axis_tdata[RATIO_BITS-1:0];
    end
  end

  rdg_history #(
    .LONG_WINDOW  (LONG_WINDOW),
    .SHORT_WINDOW (SHORT_WINDOW),
    .RATIO_BITS   (RATIO_BITS)
  ) u_history (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .ratio      (ratio_q),
    .long_mean  (long_mean),
    .short_mean (short_mean),
    .stat       (win_stat)
  );

  rdg_grader #(
    .RATIO_BITS (RATIO_BITS)
  ) u_grader (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .ratio         (ratio_q),
    .long_mean     (long_mean),
    .short_mean    (short_mean),
    .stat          (win_stat),
    .reference_min (reference_min),
    .reference_max (reference_max),
    .ratio_grade   (ratio_grade),
    .trend_grade   (trend_grade),
    .level         (level)
  );

  rdg_alert u_alert (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .level          (level),
    .group_length   (group_length),
    .majority_count (majority_count),
    .alert          (alert),
    .closed         (closed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      level_q       <= level;
      ratio_grade_q <= ratio_grade;
      trend_grade_q <= trend_grade;
      alert_q       <= alert;
      closed_q      <= closed;
    end
  end

  // tdata from bit 0: level, ratio_grade, trend_grade, alert, zero padding
  assign m_axis_tdata = {5'd0, alert_q, trend_grade_q, ratio_grade_q, level_q};
  assign m_axis_tlast = closed_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for ratio_drowsiness_grader: sample stream in, graded beats out
// depends on rdg_pkg and the rtl/core sources; needs nothing else to run
`timescale 1ns / 1ps

module tb_top;

  // geometry of the history the grader keeps
  localparam int LONG      = rdg_pkg::LONG_WINDOW_DEF;
  localparam int SHORT     = rdg_pkg::SHORT_WINDOW_DEF;
  localparam int HIST      = LONG + 1;
  localparam int ONE_Q8    = 256;    // 1.0 in Q8.8
  localparam int HALF_Q8   = 128;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;  // long consumer hold-off in the pressure phase
  localparam int DRAIN_SLACK = 12;   // extra wait after the last drain, before the summary is printed
  localparam int PRINT_CAP   = 40;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one graded result as it should leave the block
  typedef struct packed {
    logic [2:0] level;
    logic [2:0] ratio_grade;
    logic [2:0] trend_grade;
    logic [1:0] alert;
    logic       closed;
  } grade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // ratio
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // level, ratio_grade, trend_grade, alert, zero fill
  logic        m_axis_tlast;         // alert_updated
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  ratio_drowsiness_grader dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the grader state, starting from its reset values
  // ---------------------------------------------------------------------------
  logic [15:0] hist [0:HIST-1];
  int          hist_wr       = 0;
  int          seen_count    = 0;   // saturates at HIST
  int          refresh_phase = 0;
  logic [15:0] ref_level     = '0;
  logic [15:0] prev_mean     = '0;
  bit          have_prev_mean = 1'b0;
  logic [4:0]  grp_pos  = 5'd1;
  logic [4:0]  n_green  = '0;
  logic [4:0]  n_yellow = '0;
  logic [4:0]  n_red    = '0;
  logic [1:0]  verdict  = rdg_pkg::ALERT_YELLOW;

  // shadow registers
  logic [15:0] lim_lo   = rdg_pkg::REFERENCE_MIN_RST;
  logic [15:0] lim_hi   = rdg_pkg::REFERENCE_MAX_RST;
  logic [4:0]  grp_len  = rdg_pkg::GROUP_LENGTH_RST;
  logic [4:0]  majority = rdg_pkg::MAJORITY_COUNT_RST;

  // sample of the given age, age 0 being the newest
  function automatic logic [15:0] past(input int age);
    return hist[(hist_wr + HIST - age) % HIST];
  endfunction

  // short window sum as seen by the sample that arrives 'ahead' beats from now
  function automatic int short_sum_at(input int ahead);
    int s, a;
    s = 0;
    for (a = LONG - SHORT; a < LONG; a = a + 1) s += past(a - ahead);
    return s;
  endfunction

  function automatic logic [4:0] bump(input logic [4:0] c);
    return (&c) ? c : c + 5'd1;
  endfunction

  // advance the shadow state by one sample and return what the block should emit
  function automatic grade_t grade_sample(input logic [15:0] r);
    grade_t      g;
    int unsigned lsum, mean, refv, rr, rf;
    int          diff, a;
    bit          warm_done;
    logic [14:0] row;
    warm_done = seen_count >= HIST;
    g = '0;
    g.ratio_grade = rdg_pkg::RATIO_GRADE_ABOVE;
    g.trend_grade = rdg_pkg::TREND_GRADE_FLAT;
    hist_wr = (hist_wr + 1) % HIST;
    hist[hist_wr] = r;
    if (warm_done) begin
      // reference rebuilt once per long window from the samples before this one
      if (refresh_phase == 0) begin
        lsum = 0;
        for (a = 1; a <= LONG; a = a + 1) lsum += past(a);
        mean = lsum / LONG;
        refv = have_prev_mean ? (prev_mean + mean) / 2 : mean;
        prev_mean = mean[15:0];
        have_prev_mean = 1'b1;
        // upper clamp is checked first; with crossed limits a value above it gets the upper one, any other the lower
        if (refv > lim_hi) refv = lim_hi;
        else if (refv < lim_lo) refv = lim_lo;
        ref_level = refv[15:0];
      end
      refresh_phase = (refresh_phase + 1) % LONG;
      rr = r;
      rf = ref_level;
      // exact compares against 1, 0.8, 0.65, 0.5 and 0.35 of the reference
      if (rf <= rr) g.ratio_grade = 3'd6;
      else if (rf * 4 <= rr * 5) g.ratio_grade = 3'd5;
      else if (rf * 13 <= rr * 20) g.ratio_grade = 3'd4;
      else if (rf <= rr * 2) g.ratio_grade = 3'd3;
      else if (rf * 7 <= rr * 20) g.ratio_grade = 3'd2;
      else g.ratio_grade = 3'd1;
      diff = short_sum_at(0) / SHORT - int'(rr);
      if (diff >= ONE_Q8) g.trend_grade = 3'd1;
      else if (diff >= HALF_Q8) g.trend_grade = 3'd2;
      else if (diff >= 0) g.trend_grade = 3'd3;
      else if (diff >= -HALF_Q8) g.trend_grade = 3'd4;
      else g.trend_grade = 3'd5;
    end
    if (seen_count < HIST) seen_count++;
    // level map, trend grade 1 in the top bits of each row
    case (g.ratio_grade)
      3'd1:    row = {3'd1, 3'd1, 3'd1, 3'd2, 3'd2};
      3'd2:    row = {3'd1, 3'd1, 3'd2, 3'd2, 3'd3};
      3'd3:    row = {3'd2, 3'd2, 3'd3, 3'd3, 3'd4};
      3'd4:    row = {3'd3, 3'd3, 3'd4, 3'd4, 3'd5};
      3'd5:    row = {3'd4, 3'd5, 3'd5, 3'd5, 3'd5};
      default: row = {3'd5, 3'd5, 3'd5, 3'd5, 3'd5};
    endcase
    g.level = row[14 - 3 * (g.trend_grade - 1) -: 3];
    // group closes on a match, so a length of zero closes only after the wrap
    if (grp_pos == grp_len) begin
      if (n_green >= majority) verdict = rdg_pkg::ALERT_GREEN;
      else if (n_red >= majority) verdict = rdg_pkg::ALERT_RED;
      else verdict = rdg_pkg::ALERT_YELLOW;
      n_green  = '0;
      n_yellow = '0;
      n_red    = '0;
      grp_pos  = 5'd1;
      g.closed = 1'b1;
    end else begin
      grp_pos = grp_pos + 5'd1;
    end
    if (g.level == rdg_pkg::LEVEL_GREEN) n_green = bump(n_green);
    else if (g.level >= rdg_pkg::LEVEL_YELLOW_MIN) n_yellow = bump(n_yellow);
    else n_red = bump(n_red);
    g.alert = verdict;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queue, expected results and bookkeeping
  // ---------------------------------------------------------------------------
  logic [15:0] ratios_to_send [$];
  grade_t      due_grades [$];
  bit          ratio_held = 1'b0;   // a beat is on the input and not yet taken

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int band_centre    = 900;
  int band_width     = 400;

  int hold_left = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  int cycle_count   = 0;
  int mismatches    = 0;
  int items_taken   = 0;
  int results_seen  = 0;
  int groups_closed = 0;
  int grade_hits [1:6] = '{0, 0, 0, 0, 0, 0};

  // one line per mismatch, quiet after the first PRINT_CAP but always counted
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 69; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default:       begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all four registers; the five-bit ones get junk in the unused upper bits
  task automatic set_config(input logic [15:0] lo, input logic [15:0] hi,
                            input logic [4:0] glen, input logic [4:0] maj);
    logic [10:0] junk;
    junk = 11'($urandom_range(0, 2047));
    write_reg(rdg_pkg::CFG_REFERENCE_MIN, lo);
    write_reg(rdg_pkg::CFG_REFERENCE_MAX, hi);
    write_reg(rdg_pkg::CFG_GROUP_LENGTH, {junk, glen});
    junk = 11'($urandom_range(0, 2047));
    write_reg(rdg_pkg::CFG_MAJORITY_COUNT, {junk, maj});
  endtask

  // samples drift in bands so that reference, short mean and sample pull apart;
  // a few full-range values and rails keep every bit of the field moving
  task automatic feed(input int count);
    int i, roll, v;
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        band_centre = $urandom_range(100, 1800);
        band_width  = $urandom_range(16, 700);
      end
      if (roll >= 96) begin
        v = $urandom_range(0, 65535);
      end else if (roll >= 94) begin
        v = roll[0] ? 65535 : 0;
      end else begin
        v = band_centre + int'($urandom_range(0, 2 * band_width)) - band_width;
        if (v < 0) v = 0;
      end
      ratios_to_send.push_back(v[15:0]);
    end
  endtask

  // wait until every sample is taken and every result has come back
  task automatic drain();
    do @(negedge clk); while (ratios_to_send.size() != 0 || ratio_held || due_grades.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // sample driver: one beat at a time, held until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!ratio_held) begin
      if (ratios_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= ratios_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        ratio_held = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // consumer ready, forced low during the long hold-off
  always @(negedge clk) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // hold-off counter, started once on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: register writes, accepted samples and results, all at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    grade_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdg_pkg::CFG_REFERENCE_MIN:  lim_lo   = cfg_data;
          rdg_pkg::CFG_REFERENCE_MAX:  lim_hi   = cfg_data;
          rdg_pkg::CFG_GROUP_LENGTH:   grp_len  = cfg_data[4:0];
          rdg_pkg::CFG_MAJORITY_COUNT: majority = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_grades.push_back(grade_sample(s_axis_tdata));
        ratio_held = 1'b0;
        items_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_grades.size() == 0) begin
          report_mismatch("result beat with nothing due, tdata", m_axis_tdata, 0);
        end else begin
          want = due_grades.pop_front();
          if (m_axis_tdata[2:0] != want.level)
            report_mismatch("level", m_axis_tdata[2:0], want.level);
          if (m_axis_tdata[5:3] != want.ratio_grade)
            report_mismatch("ratio_grade", m_axis_tdata[5:3], want.ratio_grade);
          if (m_axis_tdata[8:6] != want.trend_grade)
            report_mismatch("trend_grade", m_axis_tdata[8:6], want.trend_grade);
          if (m_axis_tdata[10:9] != want.alert)
            report_mismatch("alert", m_axis_tdata[10:9], want.alert);
          if (m_axis_tdata[15:11] != '0)
            report_mismatch("tdata fill bits", m_axis_tdata[15:11], 0);
          if (m_axis_tlast != want.closed)
            report_mismatch("alert_updated", m_axis_tlast, want.closed);
          grade_hits[want.ratio_grade]++;
          if (want.closed) groups_closed++;
          results_seen++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d results still due", cycle_count,
               due_grades.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          j, v, p;
    int unsigned rf;
    int unsigned edges [0:4];
    int          steps [0:7];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, no idling; rails and bit patterns land in the warm-up stretch
    set_config(rdg_pkg::REFERENCE_MIN_RST, rdg_pkg::REFERENCE_MAX_RST,
               rdg_pkg::GROUP_LENGTH_RST, rdg_pkg::MAJORITY_COUNT_RST);
    set_idling(IDLE_NONE);
    ratios_to_send.push_back(16'h0000);
    ratios_to_send.push_back(16'hFFFF);
    ratios_to_send.push_back(16'h5555);
    ratios_to_send.push_back(16'hAAAA);
    ratios_to_send.push_back(16'h8000);
    ratios_to_send.push_back(16'h7FFF);
    feed(180);
    drain();

    // samples right on each trend and ratio boundary and one below it,
    // only while the reference is known to stay put
    if (seen_count >= HIST && refresh_phase != 0 && LONG - refresh_phase >= 18) begin
      steps = '{ONE_Q8, ONE_Q8 - 1, HALF_Q8, HALF_Q8 - 1, 0, -1, -HALF_Q8, -HALF_Q8 - 1};
      for (j = 1; j <= 8; j++) begin
        v = short_sum_at(j) / SHORT - steps[j - 1];
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        ratios_to_send.push_back(v[15:0]);
      end
      rf = ref_level;
      edges[0] = rf;
      edges[1] = (4 * rf + 4) / 5;
      edges[2] = (13 * rf + 19) / 20;
      edges[3] = (rf + 1) / 2;
      edges[4] = (7 * rf + 19) / 20;
      for (j = 0; j < 5; j++) begin
        ratios_to_send.push_back(edges[j][15:0]);
        ratios_to_send.push_back(edges[j] == 0 ? 16'd0 : edges[j][15:0] - 16'd1);
      end
      drain();
    end

    // reference follows the mean unclamped; every level closes a group
    set_config(16'h0000, 16'hFFFF, 5'd1, 5'd1);
    set_idling(IDLE_SENDER);
    feed(150);
    drain();

    // crossed limits and a zero group length: groups of 32, counters saturate
    set_config(16'hFFFF, 16'h0000, 5'd0, 5'd31);
    set_idling(IDLE_RECEIVER);
    feed(150);
    drain();

    // narrow reference band, group length of 31
    set_config(16'd300, 16'd900, 5'd31, 5'd16);
    set_idling(IDLE_BOTH);
    feed(200);
    drain();

    // back to reset values; consumer holds off while the sender keeps offering
    set_config(rdg_pkg::REFERENCE_MIN_RST, rdg_pkg::REFERENCE_MAX_RST,
               rdg_pkg::GROUP_LENGTH_RST, rdg_pkg::MAJORITY_COUNT_RST);
    set_idling(IDLE_NONE);
    hold_req = 1'b1;
    feed(150);
    drain();

    // random settings, limits may cross
    for (p = 0; p < 3; p++) begin
      set_config(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 2000)),
                 5'($urandom_range(1, 31)), 5'($urandom_range(1, 31)));
      set_idling(idle_mode_t'($urandom_range(0, 3)));
      feed(100);
      drain();
    end

    repeat (DRAIN_SLACK) @(negedge clk);
    $display("covered %0d samples over 8 register settings, %0d results checked, %0d groups closed",
             items_taken, results_seen, groups_closed);
    $display("ratio grades 1 to 6 seen %0d %0d %0d %0d %0d %0d", grade_hits[1], grade_hits[2],
             grade_hits[3], grade_hits[4], grade_hits[5], grade_hits[6]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== ratio_drowsiness_grader.f =====
rtl/core/rdg_pkg.sv
rtl/core/rdg_history.sv
rtl/core/rdg_grader.sv
rtl/core/rdg_alert.sv
rtl/core/ratio_drowsiness_grader.sv
test/tb_top.sv
